/* rtl/pva_pkg.sv */
package pva_pkg;

   localparam int unsigned DEFAULT_MAX_VOICES = 16;
   localparam int unsigned VOICES_RESET       = 8;

   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned NOTE_W     = 7;
   localparam int unsigned CHAN_W     = 5;
   localparam int unsigned VEL_W      = 7;
   localparam int unsigned FIN_W      = 4;
   localparam int unsigned ACTION_W   = 2;
   localparam int unsigned IDX_OUT_W  = 4;
   localparam int unsigned MASK_W     = 16;
   localparam int unsigned COUNT_IN_W = 5;

   // Register file: one 32-bit register, word aligned.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [0:0]  CSR_VOICES_IN_USE = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_NOTE_ON   = 2'd0,
      FUNC_NOTE_OFF  = 2'd1,
      FUNC_VOICE_END = 2'd2,
      FUNC_CUT_ALL   = 2'd3
   } func_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE    = 2'd0,
      ACT_START   = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_CUT     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [NOTE_W-1:0] note;
      logic [CHAN_W-1:0] chan;
   } voice_entry_type;

endpackage

/* rtl/pva_voice_ram.sv */
// Note and channel store, one read and one write port, registered read.
// Entries that were never written since the last clear read as zero.
module pva_voice_ram #(
   parameter int unsigned MAX_VOICES = pva_pkg::DEFAULT_MAX_VOICES,
   parameter int unsigned VIDX_W     = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     wr_en,
   input  logic [VIDX_W-1:0]        wr_addr,
   input  pva_pkg::voice_entry_type wr_data,
   input  logic                     rd_en,
   input  logic [VIDX_W-1:0]        rd_addr,
   output pva_pkg::voice_entry_type rd_data
);

   pva_pkg::voice_entry_type mem [MAX_VOICES];
   pva_pkg::voice_entry_type rd_raw_ff;
   logic                     rd_written_ff;
   logic [MAX_VOICES-1:0]    written_ff;
   logic [MAX_VOICES-1:0]    written_in;

   always_comb begin
      written_in = written_ff;
      if (clear) begin
         written_in = '0;
      end else if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_raw_ff     <= mem[rd_addr];
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   assign rd_data = rd_written_ff ? rd_raw_ff : '0;

   // The sequencer never reads and writes the same entry in one cycle.
   assert property (@(posedge clock) disable iff (reset)
      wr_en && rd_en |-> wr_addr != rd_addr)
      else $error("voice store read and write collide");

endmodule

/* rtl/pva_ctrl.sv */
// Sequencer: accepts one event, scans the voice store one entry per cycle
// when the event needs it, then commits the update and loads the result.
module pva_ctrl #(
   parameter int unsigned MAX_VOICES = pva_pkg::DEFAULT_MAX_VOICES,
   parameter int unsigned VIDX_W     = 4,
   parameter int unsigned CNT_W      = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cfg_clear,
   input  logic [CNT_W-1:0]                  count,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pva_pkg::FUNC_W-1:0]        req_func,
   input  logic [pva_pkg::NOTE_W-1:0]        req_note_number,
   input  logic [pva_pkg::CHAN_W-1:0]        req_midi_channel,
   input  logic [pva_pkg::VEL_W-1:0]         req_velocity,
   input  logic [pva_pkg::FIN_W-1:0]         req_finished_voice,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pva_pkg::ACTION_W-1:0]      rsp_action,
   output logic [pva_pkg::IDX_OUT_W-1:0]     rsp_voice_index,
   output logic                              rsp_was_stolen,
   output logic [pva_pkg::MASK_W-1:0]        rsp_release_mask,
   output logic [pva_pkg::NOTE_W-1:0]        rsp_start_note,
   output logic [pva_pkg::VEL_W-1:0]         rsp_start_velocity,
   output logic                              mem_wr_en,
   output logic [VIDX_W-1:0]                 mem_wr_addr,
   output pva_pkg::voice_entry_type          mem_wr_data,
   output logic                              mem_rd_en,
   output logic [VIDX_W-1:0]                 mem_rd_addr,
   input  pva_pkg::voice_entry_type          mem_rd_data
);

   localparam int unsigned PICK_WIDE_W = VIDX_W + pva_pkg::IDX_OUT_W;

   pva_pkg::state_type state_ff, state_in;

   pva_pkg::func_type            func_ff, func_in;
   logic [pva_pkg::NOTE_W-1:0]   note_ff, note_in;
   logic [pva_pkg::CHAN_W-1:0]   chan_ff, chan_in;
   logic [pva_pkg::VEL_W-1:0]    vel_ff, vel_in;
   logic [pva_pkg::FIN_W-1:0]    fin_ff, fin_in;

   logic [CNT_W-1:0]             rd_cnt_ff, rd_cnt_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic [VIDX_W-1:0]            chk_idx_ff, chk_idx_in;
   logic                         chk_busy_ff, chk_busy_in;
   logic                         found_ff, found_in;
   logic [VIDX_W-1:0]            pick_ff, pick_in;
   logic [pva_pkg::NOTE_W-1:0]   min_note_ff, min_note_in;
   logic [VIDX_W-1:0]            min_idx_ff, min_idx_in;
   logic [pva_pkg::MASK_W-1:0]   mask_ff, mask_in;
   logic [MAX_VOICES-1:0]        busy_ff, busy_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   pva_pkg::action_type          rsp_action_ff, rsp_action_in;
   logic [pva_pkg::IDX_OUT_W-1:0] rsp_index_ff, rsp_index_in;
   logic                         rsp_stolen_ff, rsp_stolen_in;
   logic [pva_pkg::MASK_W-1:0]   rsp_mask_ff, rsp_mask_in;
   logic [pva_pkg::NOTE_W-1:0]   rsp_note_ff, rsp_note_in;
   logic [pva_pkg::VEL_W-1:0]    rsp_vel_ff, rsp_vel_in;

   logic [VIDX_W-1:0]            pick;
   logic [PICK_WIDE_W-1:0]       pick_wide;
   logic                         out_free;
   logic                         match;
   logic                         start_commit;

   assign pick      = found_ff ? pick_ff : min_idx_ff;
   assign pick_wide = PICK_WIDE_W'(pick);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign match     = (mem_rd_data.note == note_ff) && (mem_rd_data.chan == chan_ff);
   assign req_stall = (state_ff != pva_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      note_in       = note_ff;
      chan_in       = chan_ff;
      vel_in        = vel_ff;
      fin_in        = fin_ff;
      rd_cnt_in     = rd_cnt_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      chk_busy_in   = chk_busy_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      min_note_in   = min_note_ff;
      min_idx_in    = min_idx_ff;
      mask_in       = mask_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_action_in = rsp_action_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_stolen_in = rsp_stolen_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_note_in   = rsp_note_ff;
      rsp_vel_in    = rsp_vel_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = rd_cnt_ff[VIDX_W-1:0];
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pick;
      mem_wr_data   = '{note: note_ff, chan: chan_ff};
      start_commit  = 1'b0;

      unique case (state_ff)
         pva_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in     = pva_pkg::func_type'(req_func);
               note_in     = req_note_number;
               chan_in     = req_midi_channel;
               vel_in      = req_velocity;
               fin_in      = req_finished_voice;
               rd_cnt_in   = '0;
               found_in    = 1'b0;
               mask_in     = '0;
               if ((func_in == pva_pkg::FUNC_NOTE_ON || func_in == pva_pkg::FUNC_NOTE_OFF)
                   && count != '0) begin
                  state_in = pva_pkg::ST_SCAN;
               end else begin
                  state_in = pva_pkg::ST_FINISH;
               end
            end
         end

         pva_pkg::ST_SCAN: begin
            if (rd_cnt_ff < count) begin
               mem_rd_en   = 1'b1;
               rd_cnt_in   = CNT_W'(rd_cnt_ff + 1'b1);
               chk_vld_in  = 1'b1;
               chk_idx_in  = rd_cnt_ff[VIDX_W-1:0];
               chk_busy_in = busy_ff[rd_cnt_ff[VIDX_W-1:0]];
            end
            if (chk_vld_ff) begin
               if (!found_ff && !chk_busy_ff) begin
                  found_in = 1'b1;
                  pick_in  = chk_idx_ff;
               end
               if (chk_idx_ff == '0 || mem_rd_data.note < min_note_ff) begin
                  min_note_in = mem_rd_data.note;
                  min_idx_in  = chk_idx_ff;
               end
               for (int b = 0; b < int'(pva_pkg::MASK_W); b++) begin
                  if (match && int'(chk_idx_ff) == b) begin
                     mask_in[b] = 1'b1;
                  end
               end
               if (int'(chk_idx_ff) == int'(count) - 1) begin
                  state_in = pva_pkg::ST_FINISH;
               end
            end
         end

         pva_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in      = pva_pkg::ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_action_in = pva_pkg::ACT_NONE;
               rsp_index_in  = '0;
               rsp_stolen_in = 1'b0;
               rsp_mask_in   = '0;
               rsp_note_in   = '0;
               rsp_vel_in    = '0;
               unique case (func_ff)
                  pva_pkg::FUNC_NOTE_ON: begin
                     if (count != '0) begin
                        start_commit  = 1'b1;
                        mem_wr_en     = 1'b1;
                        busy_in[pick] = 1'b1;
                        rsp_action_in = pva_pkg::ACT_START;
                        rsp_index_in  = pick_wide[pva_pkg::IDX_OUT_W-1:0];
                        rsp_stolen_in = !found_ff;
                        rsp_note_in   = note_ff;
                        rsp_vel_in    = vel_ff;
                     end
                  end
                  pva_pkg::FUNC_NOTE_OFF: begin
                     rsp_action_in = pva_pkg::ACT_RELEASE;
                     rsp_mask_in   = mask_ff;
                  end
                  pva_pkg::FUNC_VOICE_END: begin
                     for (int i = 0; i < int'(MAX_VOICES); i++) begin
                        if (int'(fin_ff) == i && int'(fin_ff) < int'(count)) begin
                           busy_in[i] = 1'b0;
                        end
                     end
                  end
                  pva_pkg::FUNC_CUT_ALL: begin
                     busy_in       = '0;
                     rsp_action_in = pva_pkg::ACT_CUT;
                  end
               endcase
            end
         end

         default: begin
            state_in = pva_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pva_pkg::ST_IDLE;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_clear) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      note_ff       <= note_in;
      chan_ff       <= chan_in;
      vel_ff        <= vel_in;
      fin_ff        <= fin_in;
      rd_cnt_ff     <= rd_cnt_in;
      chk_idx_ff    <= chk_idx_in;
      chk_busy_ff   <= chk_busy_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      min_note_ff   <= min_note_in;
      min_idx_ff    <= min_idx_in;
      mask_ff       <= mask_in;
      rsp_action_ff <= rsp_action_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_stolen_ff <= rsp_stolen_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_note_ff   <= rsp_note_in;
      rsp_vel_ff    <= rsp_vel_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_voice_index    = rsp_index_ff;
   assign rsp_was_stolen     = rsp_stolen_ff;
   assign rsp_release_mask   = rsp_mask_ff;
   assign rsp_start_note     = rsp_note_ff;
   assign rsp_start_velocity = rsp_vel_ff;

   // A started voice is marked busy right after the commit.
   assert property (@(posedge clock) disable iff (reset)
      start_commit |=> busy_ff[$past(pick)])
      else $error("started voice not marked busy");

   // Read data is only checked while a scan is in progress.
   assert property (@(posedge clock) disable iff (reset)
      chk_vld_ff |-> state_ff == pva_pkg::ST_SCAN)
      else $error("scan check outside of scan");

   // The scan never runs past the voices in use.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == pva_pkg::ST_SCAN |-> rd_cnt_ff <= count)
      else $error("scan counter past voice count");

endmodule

/* rtl/polyphonic_voice_allocator_top.sv */
// Voice allocator for a polyphonic synthesizer. Each event on the req_ channel
// produces exactly one result transfer on the rsp_ channel. Note-on starts the
// first idle voice in index order, or, with every voice in use busy, steals the
// busy voice holding the lowest note (earliest index on a tie); with no voices
// in use it reports no action. Note-off reports a mask of the voices whose
// stored note and channel match and leaves them busy. Voice-finished frees one
// voice and cut-out frees all of them. Note and channel are kept in a small
// synchronous memory that is scanned one entry per cycle through its single
// read port while a note-on or note-off is handled; voice-finished and cut-out,
// and a note-on or note-off with no voices in use, skip the scan. The next
// event can be accepted as soon as the result sits in the output register,
// and that register lets a new event be taken while the previous result is
// still stalled. The only register, voices_in_use at byte address 0,
// saturates at MAX_VOICES, resets to 8 (or to MAX_VOICES if smaller), and
// writing it clears the whole voice table; it must only be written while no
// event is in flight.
module polyphonic_voice_allocator_top #(
   parameter int unsigned MAX_VOICES = pva_pkg::DEFAULT_MAX_VOICES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pva_pkg::FUNC_W-1:0]          req_func,
   input  logic [pva_pkg::NOTE_W-1:0]          req_note_number,
   input  logic [pva_pkg::CHAN_W-1:0]          req_midi_channel,
   input  logic [pva_pkg::VEL_W-1:0]           req_velocity,
   input  logic [pva_pkg::FIN_W-1:0]           req_finished_voice,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pva_pkg::ACTION_W-1:0]        rsp_action,
   output logic [pva_pkg::IDX_OUT_W-1:0]       rsp_voice_index,
   output logic                                rsp_was_stolen,
   output logic [pva_pkg::MASK_W-1:0]          rsp_release_mask,
   output logic [pva_pkg::NOTE_W-1:0]          rsp_start_note,
   output logic [pva_pkg::VEL_W-1:0]           rsp_start_velocity,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pva_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pva_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pva_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   // Voice index width is at least one bit so that a single voice still works.
   localparam int unsigned VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int unsigned CNT_W  = $clog2(MAX_VOICES + 1);
   // Width that holds both the written field and MAX_VOICES for the clamp.
   localparam int unsigned CMP_W  =
      (CNT_W > pva_pkg::COUNT_IN_W) ? CNT_W : pva_pkg::COUNT_IN_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_VOICES);
   localparam logic [CNT_W-1:0] RESET_COUNT =
      (pva_pkg::VOICES_RESET > MAX_VOICES) ? CNT_W'(MAX_VOICES)
                                           : CNT_W'(pva_pkg::VOICES_RESET);

   logic [CNT_W-1:0]          voices_ff, voices_in;
   logic                      csr_write;
   logic                      csr_hit;
   logic [CMP_W-1:0]          wr_count;

   logic                      mem_wr_en;
   logic [VIDX_W-1:0]         mem_wr_addr;
   pva_pkg::voice_entry_type  mem_wr_data;
   logic                      mem_rd_en;
   logic [VIDX_W-1:0]         mem_rd_addr;
   pva_pkg::voice_entry_type  mem_rd_data;

   // A write lands on the access cycle; the address is decoded on whole words.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[pva_pkg::CSR_ADDR_W-1:2] == pva_pkg::CSR_VOICES_IN_USE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign wr_count   = CMP_W'(csr_pwdata[pva_pkg::COUNT_IN_W-1:0]);

   // Counts above the table size saturate at the table size.
   always_comb begin
      voices_in = voices_ff;
      if (csr_write) begin
         voices_in = (wr_count > MAX_CMP) ? CNT_W'(MAX_VOICES) : CNT_W'(wr_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voices_ff <= RESET_COUNT;
      end else begin
         voices_ff <= voices_in;
      end
   end

   assign csr_prdata = csr_hit ? pva_pkg::CSR_DATA_W'(voices_ff) : '0;

   pva_voice_ram #(
      .MAX_VOICES (MAX_VOICES),
      .VIDX_W     (VIDX_W)
   ) u_voice_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (csr_write),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   pva_ctrl #(
      .MAX_VOICES (MAX_VOICES),
      .VIDX_W     (VIDX_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .cfg_clear          (csr_write),
      .count              (voices_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_note_number    (req_note_number),
      .req_midi_channel   (req_midi_channel),
      .req_velocity       (req_velocity),
      .req_finished_voice (req_finished_voice),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_action         (rsp_action),
      .rsp_voice_index    (rsp_voice_index),
      .rsp_was_stolen     (rsp_was_stolen),
      .rsp_release_mask   (rsp_release_mask),
      .rsp_start_note     (rsp_start_note),
      .rsp_start_velocity (rsp_start_velocity),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data)
   );

endmodule

/* test/polyphonic_voice_allocator_top_test.sv */
module polyphonic_voice_allocator_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned VOICE_SLOTS = pva_pkg::DEFAULT_MAX_VOICES;
   // A note-on or note-off scans every voice in use before its result comes out.
   localparam int unsigned SETTLE_CYCLES = VOICE_SLOTS + 8;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned RANDOM_PHASES = 10;
   localparam int unsigned PHASE_ITEMS = 103;
   localparam int unsigned REPORT_LIMIT = 10;

   // One MIDI event as it crosses the request channel.
   typedef struct {
      pva_pkg::func_type          func;
      logic [pva_pkg::NOTE_W-1:0] note;
      logic [pva_pkg::CHAN_W-1:0] chan;
      logic [pva_pkg::VEL_W-1:0]  vel;
      logic [pva_pkg::FIN_W-1:0]  fin;
   } midi_msg_type;

   // One allocation decision as it crosses the result channel.
   typedef struct {
      pva_pkg::action_type           action;
      logic [pva_pkg::IDX_OUT_W-1:0] voice;
      logic                          stolen;
      logic [pva_pkg::MASK_W-1:0]    mask;
      logic [pva_pkg::NOTE_W-1:0]    note;
      logic [pva_pkg::VEL_W-1:0]     vel;
   } alloc_result_type;

   // The scoreboard keeps its own copy of the voice table. Each accepted event is
   // applied to that copy at once, and the decision it leads to is queued until
   // the matching result transfer shows up.
   class voice_scoreboard;
      int unsigned                voice_count;
      bit                         busy [VOICE_SLOTS];
      logic [pva_pkg::NOTE_W-1:0] held_note [VOICE_SLOTS];
      logic [pva_pkg::CHAN_W-1:0] held_chan [VOICE_SLOTS];
      alloc_result_type           expected_decisions [$];
      int unsigned                failures;

      function new();
         failures = 0;
         voice_count = (pva_pkg::VOICES_RESET > VOICE_SLOTS) ? VOICE_SLOTS
                                                             : pva_pkg::VOICES_RESET;
         clear_voices();
      endfunction

      function void clear_voices();
         for (int i = 0; i < VOICE_SLOTS; i++) begin
            busy[i] = 1'b0;
            held_note[i] = '0;
            held_chan[i] = '0;
         end
      endfunction

      function void set_voice_count(logic [pva_pkg::CSR_DATA_W-1:0] value);
         int unsigned requested;
         requested = 32'(value[pva_pkg::COUNT_IN_W-1:0]);
         voice_count = (requested > VOICE_SLOTS) ? VOICE_SLOTS : requested;
         clear_voices();
      endfunction

      function int unsigned pending();
         return expected_decisions.size();
      endfunction

      function void fail(string text);
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, text);
         end
      endfunction

      // Applies one event to the voice table and returns the decision it causes.
      function alloc_result_type allocate(midi_msg_type m);
         alloc_result_type r;
         int unsigned      pick;
         bit               found;
         r.action = pva_pkg::ACT_NONE;
         r.voice = '0;
         r.stolen = 1'b0;
         r.mask = '0;
         r.note = '0;
         r.vel = '0;
         case (m.func)
            pva_pkg::FUNC_NOTE_ON: begin
               if (voice_count != 0) begin
                  found = 1'b0;
                  pick = 0;
                  for (int i = 0; i < voice_count; i++) begin
                     if (!found && !busy[i]) begin
                        pick = i;
                        found = 1'b1;
                     end
                  end
                  // Every voice is busy, so take the lowest note, earliest on a tie.
                  if (!found) begin
                     for (int i = 1; i < voice_count; i++) begin
                        if (held_note[i] < held_note[pick]) pick = i;
                     end
                  end
                  busy[pick] = 1'b1;
                  held_note[pick] = m.note;
                  held_chan[pick] = m.chan;
                  r.action = pva_pkg::ACT_START;
                  r.voice = pva_pkg::IDX_OUT_W'(pick);
                  r.stolen = !found;
                  r.note = m.note;
                  r.vel = m.vel;
               end
            end
            pva_pkg::FUNC_NOTE_OFF: begin
               // Idle voices still hold their last note, so they can match as well.
               for (int i = 0; i < voice_count; i++) begin
                  if (i < pva_pkg::MASK_W && held_note[i] == m.note
                      && held_chan[i] == m.chan)
                     r.mask[i] = 1'b1;
               end
               r.action = pva_pkg::ACT_RELEASE;
            end
            pva_pkg::FUNC_VOICE_END: begin
               if (m.fin < voice_count) busy[m.fin] = 1'b0;
            end
            default: begin
               for (int i = 0; i < VOICE_SLOTS; i++) busy[i] = 1'b0;
               r.action = pva_pkg::ACT_CUT;
            end
         endcase
         return r;
      endfunction

      function void note_accepted(midi_msg_type m);
         expected_decisions.push_back(allocate(m));
      endfunction

      function void check_result(alloc_result_type got);
         alloc_result_type want;
         if (expected_decisions.size() == 0) begin
            fail($sformatf("result with action %0d arrived with nothing outstanding",
                           got.action));
            return;
         end
         want = expected_decisions.pop_front();
         if (got.action !== want.action)
            fail($sformatf("action: expected %0d, got %0d", want.action, got.action));
         if (got.voice !== want.voice)
            fail($sformatf("voice_index: expected %0d, got %0d", want.voice, got.voice));
         if (got.stolen !== want.stolen)
            fail($sformatf("was_stolen: expected %0d, got %0d", want.stolen, got.stolen));
         if (got.mask !== want.mask)
            fail($sformatf("release_mask: expected %h, got %h", want.mask, got.mask));
         if (got.note !== want.note)
            fail($sformatf("start_note: expected %0d, got %0d", want.note, got.note));
         if (got.vel !== want.vel)
            fail($sformatf("start_velocity: expected %0d, got %0d", want.vel, got.vel));
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [pva_pkg::FUNC_W-1:0]       req_func;
   logic [pva_pkg::NOTE_W-1:0]       req_note_number;
   logic [pva_pkg::CHAN_W-1:0]       req_midi_channel;
   logic [pva_pkg::VEL_W-1:0]        req_velocity;
   logic [pva_pkg::FIN_W-1:0]        req_finished_voice;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [pva_pkg::ACTION_W-1:0]     rsp_action;
   logic [pva_pkg::IDX_OUT_W-1:0]    rsp_voice_index;
   logic                             rsp_was_stolen;
   logic [pva_pkg::MASK_W-1:0]       rsp_release_mask;
   logic [pva_pkg::NOTE_W-1:0]       rsp_start_note;
   logic [pva_pkg::VEL_W-1:0]        rsp_start_velocity;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [pva_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [pva_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [pva_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   voice_scoreboard sb;

   // Set by the stimulus process to ask the result side for one long hold-off.
   bit hold_off_pending;

   polyphonic_voice_allocator_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_note_number    (req_note_number),
      .req_midi_channel   (req_midi_channel),
      .req_velocity       (req_velocity),
      .req_finished_voice (req_finished_voice),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_action         (rsp_action),
      .rsp_voice_index    (rsp_voice_index),
      .rsp_was_stolen     (rsp_was_stolen),
      .rsp_release_mask   (rsp_release_mask),
      .rsp_start_note     (rsp_start_note),
      .rsp_start_velocity (rsp_start_velocity),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run must end even if the block hangs. The slowest correct run is well
   // under a tenth of this.
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Offers one event at a falling edge and holds it until the block takes it.
   // The valid stays high across back-to-back transfers, so a burst needs no
   // extra assignment between items.
   task automatic send_msg(midi_msg_type m);
      @(negedge clock);
      req_valid <= 1'b1;
      req_func <= m.func;
      req_note_number <= m.note;
      req_midi_channel <= m.chan;
      req_velocity <= m.vel;
      req_finished_voice <= m.fin;
      do @(posedge clock); while (req_stall);
      sb.note_accepted(m);
   endtask

   task automatic send_fields(pva_pkg::func_type f, int unsigned note, int unsigned chan,
                              int unsigned vel, int unsigned fin);
      midi_msg_type m;
      m.func = f;
      m.note = pva_pkg::NOTE_W'(note);
      m.chan = pva_pkg::CHAN_W'(chan);
      m.vel = pva_pkg::VEL_W'(vel);
      m.fin = pva_pkg::FIN_W'(fin);
      send_msg(m);
   endtask

   task automatic idle_cycles(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stops offering events and waits until every outstanding result has been
   // transferred, then gives the block time to go fully quiet.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Two-phase register write. The block is idle whenever this is called.
   task automatic write_voice_count(logic [pva_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {pva_pkg::CSR_VOICES_IN_USE, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_voice_count(value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Builds a random event. Most are well formed: note-ons that cluster on a few
   // notes so that stealing sees ties, note-offs that name a note actually held
   // in the table, and voice-finished events aimed at voices in use. A tenth of
   // the events are left fully random.
   function automatic midi_msg_type random_msg();
      midi_msg_type m;
      int unsigned  pick;
      int unsigned  slot;
      int unsigned  n;
      n = sb.voice_count;
      m.func = pva_pkg::func_type'($urandom_range(0, 3));
      m.note = pva_pkg::NOTE_W'($urandom_range(0, 127));
      m.chan = pva_pkg::CHAN_W'($urandom_range(1, 16));
      m.vel = pva_pkg::VEL_W'($urandom_range(0, 127));
      m.fin = pva_pkg::FIN_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 10) return m;
      if (pick < 55) begin
         m.func = pva_pkg::FUNC_NOTE_ON;
         if ($urandom_range(0, 1) != 0) m.note = pva_pkg::NOTE_W'($urandom_range(60, 63));
         if ($urandom_range(0, 1) != 0) m.chan = pva_pkg::CHAN_W'($urandom_range(1, 2));
      end else if (pick < 80) begin
         m.func = pva_pkg::FUNC_NOTE_OFF;
         if (n != 0 && $urandom_range(0, 3) != 0) begin
            slot = $urandom_range(0, n - 1);
            m.note = sb.held_note[slot];
            m.chan = sb.held_chan[slot];
         end
      end else if (pick < 96) begin
         m.func = pva_pkg::FUNC_VOICE_END;
         if (n != 0 && $urandom_range(0, 5) != 0)
            m.fin = pva_pkg::FIN_W'($urandom_range(0, n - 1));
      end else begin
         m.func = pva_pkg::FUNC_CUT_ALL;
      end
      return m;
   endfunction

   // Sends events in bursts of random length. Some gaps are skipped so that long
   // back-to-back runs also occur. On request, the result side is told to hold
   // off for a long stretch early in the phase while events keep coming, and
   // the sender pauses halfway until every result is in.
   task automatic run_random_phase(int unsigned items, bit with_hold_off, bit with_pause);
      int unsigned sent;
      int unsigned burst;
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(1, 24);
         while (burst != 0 && sent < items) begin
            send_msg(random_msg());
            sent++;
            burst--;
            if (with_hold_off && sent == 8) hold_off_pending = 1'b1;
            if (with_pause && sent == items / 2) wait_for_drain();
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
      end
   endtask

   // The result side keeps switching between stall habits: never stalling,
   // stalling now and then, stalling most of the time, or stalling on a fixed
   // beat. A requested hold-off overrides the habit for its whole length.
   initial begin : result_side
      int unsigned cycle_count;
      int unsigned mode;
      int unsigned hold_left;
      cycle_count = 0;
      mode = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end
         if (cycle_count % 64 == 0) mode = $urandom_range(0, 3);
         cycle_count++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (cycle_count % 3 == 0);
            endcase
         end
      end
   end

   // Every result transfer is checked against the oldest outstanding decision.
   initial begin : result_monitor
      alloc_result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got.action = pva_pkg::action_type'(rsp_action);
            got.voice = rsp_voice_index;
            got.stolen = rsp_was_stolen;
            got.mask = rsp_release_mask;
            got.note = rsp_start_note;
            got.vel = rsp_start_velocity;
            sb.check_result(got);
         end
      end
   end

   initial begin : stimulus
      logic [pva_pkg::CSR_DATA_W-1:0] phase_values [RANDOM_PHASES];
      sb = new();
      hold_off_pending = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = pva_pkg::FUNC_NOTE_ON;
      req_note_number = '0;
      req_midi_channel = '0;
      req_velocity = '0;
      req_finished_voice = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed part with the reset count of eight voices. Fill the table with
      // a velocity of zero first, the highest note, a repeated note on one
      // channel, and two voices tied for the lowest note.
      send_fields(pva_pkg::FUNC_NOTE_ON, 5, 1, 0, 0);
      send_fields(pva_pkg::FUNC_NOTE_ON, 127, 16, 127, 15);
      send_fields(pva_pkg::FUNC_NOTE_ON, 64, 9, 100, 0);
      send_fields(pva_pkg::FUNC_NOTE_ON, 5, 2, 1, 0);
      send_fields(pva_pkg::FUNC_NOTE_ON, 64, 9, 64, 0);
      send_fields(pva_pkg::FUNC_NOTE_ON, 90, 15, 33, 0);
      send_fields(pva_pkg::FUNC_NOTE_ON, 100, 3, 77, 0);
      send_fields(pva_pkg::FUNC_NOTE_ON, 20, 8, 12, 0);
      // The table is full: the tie on the lowest note goes to the earlier voice,
      // then the other one is stolen.
      send_fields(pva_pkg::FUNC_NOTE_ON, 50, 4, 99, 0);
      send_fields(pva_pkg::FUNC_NOTE_ON, 0, 5, 55, 0);
      send_fields(pva_pkg::FUNC_NOTE_OFF, 64, 9, 0, 0);
      // A finished voice outside the count in use is ignored.
      send_fields(pva_pkg::FUNC_VOICE_END, 0, 1, 0, 15);
      send_fields(pva_pkg::FUNC_VOICE_END, 0, 1, 0, 2);
      // The freed voice still holds its note, so it is still reported.
      send_fields(pva_pkg::FUNC_NOTE_OFF, 64, 9, 0, 0);
      send_fields(pva_pkg::FUNC_NOTE_ON, 1, 16, 127, 0);
      send_fields(pva_pkg::FUNC_NOTE_OFF, 77, 3, 0, 0);
      send_fields(pva_pkg::FUNC_CUT_ALL, 0, 1, 0, 0);
      send_fields(pva_pkg::FUNC_NOTE_ON, 127, 1, 127, 0);
      wait_for_drain();

      // With no voices in use, note-on starts nothing and note-off matches nothing.
      write_voice_count('0);
      send_fields(pva_pkg::FUNC_NOTE_ON, 60, 1, 80, 0);
      send_fields(pva_pkg::FUNC_NOTE_OFF, 0, 16, 0, 0);
      send_fields(pva_pkg::FUNC_VOICE_END, 0, 1, 0, 0);
      send_fields(pva_pkg::FUNC_CUT_ALL, 0, 1, 0, 0);
      wait_for_drain();

      // The random phases go through the extremes, counts above the voice limit
      // that must saturate, and values with junk in the unused upper bits.
      phase_values[0] = 32'd1;
      phase_values[1] = 32'hFFFF_FFFF;
      phase_values[2] = 32'd16;
      phase_values[3] = 32'd0;
      phase_values[4] = 32'd2;
      phase_values[5] = 32'hA5A5_A5F0;
      phase_values[6] = 32'd5;
      phase_values[7] = 32'd17;
      phase_values[8] = 32'd12;
      phase_values[9] = {27'($urandom_range(0, 32'h07FF_FFFF)),
                         5'($urandom_range(0, 31))};
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_voice_count(phase_values[p]);
         run_random_phase(PHASE_ITEMS, p == 2, p == 4);
         wait_for_drain();
      end

      // wait_for_drain has already waited for the last result and let the block
      // settle, so any late or extra transfer would have been flagged by now.
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* polyphonic_voice_allocator_top.f */
rtl/pva_pkg.sv
rtl/pva_voice_ram.sv
rtl/pva_ctrl.sv
rtl/polyphonic_voice_allocator_top.sv
test/polyphonic_voice_allocator_top_test.sv
